/* hw/rtl/pdcs_pkg.sv */
// ============================================================================
// pdcs_pkg
// Shared types and constants of the per-device command scheduler.
// ============================================================================
package pdcs_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_NUM_DEVICES = 128;
    localparam int MAX_RESULTS     = 16;

    localparam int DEV_W  = 7;
    localparam int TAG_W  = 8;
    localparam int TIME_W = 32;
    localparam int KIND_W = 2;
    localparam int PEND_W = 5;
    localparam int RES_W  = 5;
    localparam int DEV_SPAN = 1 << DEV_W;

    // input beat layout
    localparam int IN_DEV_LSB   = 0;
    localparam int IN_TAG_LSB   = IN_DEV_LSB + DEV_W;
    localparam int IN_DELAY_LSB = IN_TAG_LSB + TAG_W;
    localparam int IN_NOW_LSB   = IN_DELAY_LSB + TIME_W;
    localparam int IN_TDATA_W   = 80;

    // output beat layout
    localparam int OUT_DEV_LSB  = 0;
    localparam int OUT_TAG_LSB  = OUT_DEV_LSB + DEV_W;
    localparam int OUT_PEND_LSB = OUT_TAG_LSB + TAG_W;
    localparam int OUT_USED_W   = OUT_PEND_LSB + PEND_W;
    localparam int OUT_TDATA_W  = 24;

    localparam logic OP_ENQ  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [KIND_W-1:0] EV_ACCEPT = 2'd0;
    localparam logic [KIND_W-1:0] EV_DROP   = 2'd1;
    localparam logic [KIND_W-1:0] EV_SEND   = 2'd2;
    localparam logic [KIND_W-1:0] EV_DONE   = 2'd3;

    typedef struct packed {
        logic              tick;
        logic [DEV_W-1:0]  dev;
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] delay;
        logic [TIME_W-1:0] now;
    } item_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [DEV_W-1:0]  dev;
        logic [TAG_W-1:0]  tag;
        logic [PEND_W-1:0] pend;
    } ev_t;

    typedef struct packed {
        logic push;
        logic finish;
        ev_t  ev;
    } evt_req_t;

endpackage

/* hw/rtl/per_device_command_scheduler.sv */
// ============================================================================
// per_device_command_scheduler
// Ordered command queue with per-device busy marks; enqueue and tick beats.
// ============================================================================
//  port group  dir  tdata (low bit up)                          tuser     tlast
//  s_axis      in   device_id, command_tag, cmd_delay, now_ms    opcode    -
//  m_axis      out  event_device, event_tag, pending_count       event_kind last
//
//  Enqueue: the beat passes the input FIFO, the ENQ state, the hold register
//  and the output register. Tick: each entry visited takes a read step (queue
//  mux, elapsed subtract) and a decide step (busy lookup, 32-bit compare).
//  Reset clears the queue count and all busy marks; no clearing pass.
//  A two-beat input FIFO and a one-deep hold plus output register decouple
//  stalls on either side; the last result of a tick is known at scan end.
// ============================================================================
module per_device_command_scheduler
#(
    parameter int QUEUE_DEPTH = pdcs_pkg::DEF_QUEUE_DEPTH,
    parameter int NUM_DEVICES = pdcs_pkg::DEF_NUM_DEVICES
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // device_id, command_tag, cmd_delay, now_ms, zero pad
    input  logic [pdcs_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // opcode
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // event_device, event_tag, pending_count, zero pad
    output logic [pdcs_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // event_kind
    output logic [pdcs_pkg::KIND_W-1:0]       m_axis_tuser,
    output logic                              m_axis_tlast
);
    import pdcs_pkg::*;

    logic     item_valid;
    item_t    item;
    logic     item_ready;
    evt_req_t req;
    logic     evt_ready;

    pdcs_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .item_valid    (item_valid),
        .item          (item),
        .item_ready    (item_ready)
    );

    pdcs_engine
    #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .NUM_DEVICES (NUM_DEVICES)
    )
    u_engine
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_ready (item_ready),
        .req        (req),
        .evt_ready  (evt_ready)
    );

    pdcs_out u_out
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .evt_ready     (evt_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

/* hw/rtl/pdcs_front.sv */
// ============================================================================
// pdcs_front
// Input side: unpacks beats into items and queues them in a two-entry FIFO.
// ============================================================================
module pdcs_front
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [pdcs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                             s_axis_tuser,
    output logic                             item_valid,
    output pdcs_pkg::item_t                  item,
    input  logic                             item_ready
);
    import pdcs_pkg::*;

    item_t      mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       push, pop;
    item_t      in_item;

    always_comb
    begin
        in_item.tick  = (s_axis_tuser == OP_TICK);
        in_item.dev   = s_axis_tdata[IN_DEV_LSB +: DEV_W];
        in_item.tag   = s_axis_tdata[IN_TAG_LSB +: TAG_W];
        in_item.delay = s_axis_tdata[IN_DELAY_LSB +: TIME_W];
        in_item.now   = s_axis_tdata[IN_NOW_LSB +: TIME_W];
    end

    assign s_axis_tready = (fill_reg != 2'd2);
    assign item_valid    = (fill_reg != 2'd0);
    assign item          = mem_reg[rd_ptr_reg];
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = item_valid && item_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

/* hw/rtl/pdcs_engine.sv */
// ============================================================================
// pdcs_engine
// Back end: holds the command queue and busy marks, runs enqueues and scans.
// ============================================================================
module pdcs_engine
#(
    parameter int QUEUE_DEPTH = pdcs_pkg::DEF_QUEUE_DEPTH,
    parameter int NUM_DEVICES = pdcs_pkg::DEF_NUM_DEVICES
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  pdcs_pkg::item_t      item,
    output logic                 item_ready,
    output pdcs_pkg::evt_req_t   req,
    input  logic                 evt_ready
);
    import pdcs_pkg::*;

    localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOT_W = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ENQ  = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_EXEC = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]        state_reg, state_next;
    item_t             item_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [RES_W-1:0]  nres_reg, nres_next;

    logic [DEV_W-1:0]  ent_dev_reg   [QUEUE_DEPTH];
    logic [TAG_W-1:0]  ent_tag_reg   [QUEUE_DEPTH];
    logic [TIME_W-1:0] ent_delay_reg [QUEUE_DEPTH];
    logic [TIME_W-1:0] ent_start_reg [QUEUE_DEPTH];
    logic              ent_sent_reg  [QUEUE_DEPTH];
    logic [SLOT_W-1:0] ent_slot_reg  [QUEUE_DEPTH];

    logic [NUM_DEVICES-1:0] busy_reg;

    logic [DEV_W-1:0]  cur_dev_reg;
    logic [TAG_W-1:0]  cur_tag_reg;
    logic [TIME_W-1:0] cur_delay_reg;
    logic [TIME_W-1:0] cur_elap_reg;
    logic              cur_sent_reg;
    logic [SLOT_W-1:0] cur_slot_reg;

    logic [SLOT_W-1:0] slot_tab [DEV_SPAN];
    logic [SLOT_W-1:0] new_slot;
    logic [IDX_W-1:0]  rd_idx;
    logic [IDX_W-1:0]  wr_idx;
    logic [CNT_W-1:0]  cnt_inc;
    logic [CNT_W-1:0]  cnt_dec;
    logic              full;
    logic              scan_more;
    logic              issue_ok;
    logic              compl_ok;
    logic              enq_wr;
    logic              do_issue;
    logic              do_compl;

    // busy slot of each device id
    for (genvar d = 0; d < DEV_SPAN; d++)
    begin : g_slot
        assign slot_tab[d] = SLOT_W'(d % NUM_DEVICES);
    end

    assign new_slot  = slot_tab[item_reg.dev];
    assign rd_idx    = idx_reg[IDX_W-1:0];
    assign wr_idx    = cnt_reg[IDX_W-1:0];
    assign cnt_inc   = cnt_reg + CNT_W'(1);
    assign cnt_dec   = cnt_reg - CNT_W'(1);
    assign full      = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign scan_more = (idx_reg < cnt_reg) && (nres_reg < RES_W'(MAX_RESULTS));
    assign issue_ok  = !cur_sent_reg && !busy_reg[cur_slot_reg];
    assign compl_ok  = cur_sent_reg && (cur_elap_reg >= cur_delay_reg);
    assign enq_wr    = (state_reg == S_ENQ) && evt_ready && !full;
    assign do_issue  = (state_reg == S_EXEC) && issue_ok && evt_ready;
    assign do_compl  = (state_reg == S_EXEC) && compl_ok && evt_ready;
    assign item_ready = (state_reg == S_IDLE);

    always_comb
    begin
        req.push   = (state_reg == S_ENQ) ||
                     ((state_reg == S_EXEC) && (issue_ok || compl_ok));
        req.finish = (state_reg == S_FIN);
        if (state_reg == S_ENQ)
        begin
            req.ev.kind = full ? EV_DROP : EV_ACCEPT;
            req.ev.dev  = item_reg.dev;
            req.ev.tag  = item_reg.tag;
            req.ev.pend = full ? PEND_W'(cnt_reg) : PEND_W'(cnt_inc);
        end
        else
        begin
            req.ev.kind = issue_ok ? EV_SEND : EV_DONE;
            req.ev.dev  = cur_dev_reg;
            req.ev.tag  = cur_tag_reg;
            req.ev.pend = issue_ok ? PEND_W'(cnt_reg) : PEND_W'(cnt_dec);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        nres_next  = nres_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = item.tick ? S_READ : S_ENQ;
                    idx_next   = '0;
                    nres_next  = '0;
                end
            end
            S_ENQ:
            begin
                if (evt_ready)
                begin
                    state_next = S_FIN;
                    if (!full)
                    begin
                        cnt_next = cnt_inc;
                    end
                end
            end
            S_READ:
            begin
                state_next = scan_more ? S_EXEC : S_FIN;
            end
            S_EXEC:
            begin
                if (issue_ok || compl_ok)
                begin
                    if (evt_ready)
                    begin
                        state_next = S_READ;
                        nres_next  = nres_reg + RES_W'(1);
                        if (issue_ok)
                        begin
                            idx_next = idx_reg + CNT_W'(1);
                        end
                        else
                        begin
                            cnt_next = cnt_dec;
                        end
                    end
                end
                else
                begin
                    state_next = S_READ;
                    idx_next   = idx_reg + CNT_W'(1);
                end
            end
            S_FIN:
            begin
                if (evt_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            nres_reg  <= '0;
            busy_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            nres_reg  <= nres_next;
            if (do_issue)
            begin
                busy_reg[cur_slot_reg] <= 1'b1;
            end
            else if (do_compl)
            begin
                busy_reg[cur_slot_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
        if (state_reg == S_READ)
        begin
            cur_dev_reg   <= ent_dev_reg[rd_idx];
            cur_tag_reg   <= ent_tag_reg[rd_idx];
            cur_delay_reg <= ent_delay_reg[rd_idx];
            cur_elap_reg  <= item_reg.now - ent_start_reg[rd_idx];
            cur_sent_reg  <= ent_sent_reg[rd_idx];
            cur_slot_reg  <= ent_slot_reg[rd_idx];
        end
    end

    // each entry loads on enqueue, stamps on issue, or takes its successor
    // when an entry at or ahead of it completes
    for (genvar g = 0; g < QUEUE_DEPTH; g++)
    begin : g_ent
        localparam int NXT = (g < QUEUE_DEPTH - 1) ? g + 1 : g;

        always_ff @(posedge clk)
        begin
            if (enq_wr && (wr_idx == IDX_W'(g)))
            begin
                ent_dev_reg[g]   <= item_reg.dev;
                ent_tag_reg[g]   <= item_reg.tag;
                ent_delay_reg[g] <= item_reg.delay;
                ent_start_reg[g] <= '0;
                ent_sent_reg[g]  <= 1'b0;
                ent_slot_reg[g]  <= new_slot;
            end
            else if (do_issue && (rd_idx == IDX_W'(g)))
            begin
                ent_start_reg[g] <= item_reg.now;
                ent_sent_reg[g]  <= 1'b1;
            end
            else if (do_compl && (CNT_W'(g) >= idx_reg))
            begin
                ent_dev_reg[g]   <= ent_dev_reg[NXT];
                ent_tag_reg[g]   <= ent_tag_reg[NXT];
                ent_delay_reg[g] <= ent_delay_reg[NXT];
                ent_start_reg[g] <= ent_start_reg[NXT];
                ent_sent_reg[g]  <= ent_sent_reg[NXT];
                ent_slot_reg[g]  <= ent_slot_reg[NXT];
            end
        end
    end

endmodule

/* hw/rtl/pdcs_out.sv */
// ============================================================================
// pdcs_out
// Output side: holds back one event to mark the last, then registers the beat.
// ============================================================================
module pdcs_out
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  pdcs_pkg::evt_req_t                req,
    output logic                              evt_ready,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [pdcs_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic [pdcs_pkg::KIND_W-1:0]       m_axis_tuser,
    output logic                              m_axis_tlast
);
    import pdcs_pkg::*;

    ev_t  hold_reg;
    logic hold_v_reg, hold_v_next;
    ev_t  out_reg;
    logic out_last_reg;
    logic out_v_reg, out_v_next;
    logic take;
    logic move;

    assign evt_ready = !hold_v_reg || !out_v_reg || m_axis_tready;
    assign take      = evt_ready && (req.push || req.finish);
    assign move      = take && hold_v_reg;

    always_comb
    begin
        out_v_next  = out_v_reg && !m_axis_tready;
        hold_v_next = hold_v_reg;
        if (move)
        begin
            out_v_next = 1'b1;
        end
        if (take)
        begin
            hold_v_next = req.push;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            out_reg      <= hold_reg;
            out_last_reg <= req.finish;
        end
        if (take && req.push)
        begin
            hold_reg <= req.ev;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            hold_v_reg <= hold_v_next;
            out_v_reg  <= out_v_next;
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W - OUT_USED_W)'(0), out_reg.pend, out_reg.tag,
                            out_reg.dev};

endmodule

/* hw/rtl/pdcs_checker.sv */
// ============================================================================
// pdcs_checker
// Port-level checks on the scheduler's result stream, bound to the top level.
// ============================================================================
module pdcs_checker
#(
    parameter int QUEUE_DEPTH = pdcs_pkg::DEF_QUEUE_DEPTH
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [pdcs_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic [pdcs_pkg::KIND_W-1:0]       m_axis_tuser,
    input  logic                              m_axis_tlast
);
    import pdcs_pkg::*;

    localparam logic [PEND_W-1:0] FULL_PEND = PEND_W'(QUEUE_DEPTH);
    localparam logic              PEND_FITS = (QUEUE_DEPTH < 32);

    logic [PEND_W-1:0] pend;

    assign pend = m_axis_tdata[OUT_PEND_LSB +: PEND_W];

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
            $stable(m_axis_tlast))
        else $error("result beat changed while stalled");

    a_enq_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == EV_ACCEPT || m_axis_tuser == EV_DROP) |->
            m_axis_tlast)
        else $error("enqueue response not marked last");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == EV_DROP) |-> pend == FULL_PEND)
        else $error("drop reported with queue not full");

    a_pend_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && PEND_FITS |-> pend <= FULL_PEND)
        else $error("pending count beyond queue depth");

endmodule

bind per_device_command_scheduler pdcs_checker
#(
    .QUEUE_DEPTH (QUEUE_DEPTH)
)
u_pdcs_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

/* bench/per_device_command_scheduler_tb.sv */
`timescale 1ns / 100ps
// ============================================================================
// per_device_command_scheduler_tb
// Streams enqueue and tick beats into the scheduler and checks every event
// beat, in order, against a cycle-free model of the queue and busy marks.
// A short directed table (empty tick, field extremes, same-scan reissue,
// time wrap, full queue, a full 16-event scan) is followed by random traffic
// with random idling on both sides, a long output stall and a drain pause.
// ============================================================================
module per_device_command_scheduler_tb;

    import pdcs_pkg::*;

    localparam int QDEPTH   = DEF_QUEUE_DEPTH;
    localparam int NDEV     = DEF_NUM_DEVICES;
    localparam int N_RANDOM = 235;

    typedef struct packed {
        ev_t  ev;
        logic last;
    } sched_ev_t;

    typedef struct packed {
        item_t             beat;
        logic              typed;
        logic [KIND_W-1:0] kind;
        logic [PEND_W-1:0] pend;
    } plan_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [KIND_W-1:0]      m_axis_tuser;
    logic                   m_axis_tlast;

    // model state
    logic [DEV_W-1:0]  q_dev   [QDEPTH];
    logic [TAG_W-1:0]  q_tag   [QDEPTH];
    logic [TIME_W-1:0] q_delay [QDEPTH];
    logic [TIME_W-1:0] q_start [QDEPTH];
    logic              q_sent  [QDEPTH];
    int                q_count = 0;
    logic              dev_busy [NDEV];

    sched_ev_t step_events [$];
    sched_ev_t due_events  [$];
    plan_row_t plan [$];

    logic [TIME_W-1:0] wall_ms;
    bit tx_gaps = 1'b1;
    bit rx_gaps = 1'b1;
    int hold_cycles = 0;
    int faults = 0;
    int shown = 0;
    int beats_sent = 0;
    int enq_sent = 0;
    int kind_seen [4] = '{0, 0, 0, 0};

    per_device_command_scheduler #(
        .QUEUE_DEPTH (QDEPTH),
        .NUM_DEVICES (NDEV)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic void note_fault(input string msg);
        faults++;
        if (shown < 10)
        begin
            shown++;
            $display("%0t: %s", $realtime, msg);
        end
    endfunction

    function automatic sched_ev_t make_event(input logic [KIND_W-1:0] kind,
                                             input logic [DEV_W-1:0] dev,
                                             input logic [TAG_W-1:0] tag);
        sched_ev_t e;
        e.ev.kind = kind;
        e.ev.dev  = dev;
        e.ev.tag  = tag;
        e.ev.pend = PEND_W'(q_count);
        e.last    = 1'b0;
        return e;
    endfunction

    // one beat through the queue model; events land in step_events
    function automatic void advance_schedule(input item_t it);
        sched_ev_t         e;
        logic [TIME_W-1:0] elapsed;
        logic [DEV_W-1:0]  d;
        logic [TAG_W-1:0]  t;
        int                i;
        int                n;
        step_events.delete();
        if (it.tick == OP_ENQ)
        begin
            if (q_count < QDEPTH)
            begin
                q_dev[q_count]   = it.dev;
                q_tag[q_count]   = it.tag;
                q_delay[q_count] = it.delay;
                q_start[q_count] = '0;
                q_sent[q_count]  = 1'b0;
                q_count++;
                e = make_event(EV_ACCEPT, it.dev, it.tag);
            end
            else
                e = make_event(EV_DROP, it.dev, it.tag);
            e.last = 1'b1;
            step_events = {step_events, e};
        end
        else
        begin
            i = 0;
            n = 0;
            while (i < q_count && n < MAX_RESULTS)
            begin
                elapsed = it.now - q_start[i];
                if (!q_sent[i])
                begin
                    if (!dev_busy[q_dev[i]])
                    begin
                        q_start[i] = it.now;
                        q_sent[i]  = 1'b1;
                        dev_busy[q_dev[i]] = 1'b1;
                        step_events = {step_events,
                                       make_event(EV_SEND, q_dev[i], q_tag[i])};
                        n++;
                    end
                    i++;
                end
                else if (elapsed >= q_delay[i])
                begin
                    d = q_dev[i];
                    t = q_tag[i];
                    dev_busy[d] = 1'b0;
                    for (int j = i; j + 1 < q_count; j++)
                    begin
                        q_dev[j]   = q_dev[j + 1];
                        q_tag[j]   = q_tag[j + 1];
                        q_delay[j] = q_delay[j + 1];
                        q_start[j] = q_start[j + 1];
                        q_sent[j]  = q_sent[j + 1];
                    end
                    q_count--;
                    step_events = {step_events, make_event(EV_DONE, d, t)};
                    n++;
                end
                else
                    i++;
            end
            if (n > 0)
                step_events[step_events.size() - 1].last = 1'b1;
        end
    endfunction

    function automatic void plan_row(input logic tick, input logic [DEV_W-1:0] dev,
                                     input logic [TAG_W-1:0] tag,
                                     input logic [TIME_W-1:0] delay,
                                     input logic [TIME_W-1:0] now, input logic typed,
                                     input logic [KIND_W-1:0] kind, input int pend);
        plan_row_t r;
        r.beat.tick  = tick;
        r.beat.dev   = dev;
        r.beat.tag   = tag;
        r.beat.delay = delay;
        r.beat.now   = now;
        r.typed      = typed;
        r.kind       = kind;
        r.pend       = PEND_W'(pend);
        plan = {plan, r};
    endfunction

    function automatic item_t next_request();
        item_t it;
        int    enq_pct;
        it.dev   = DEV_W'($urandom);
        it.tag   = TAG_W'($urandom);
        it.delay = $urandom;
        it.now   = $urandom;
        enq_pct  = (q_count < 4) ? 70 : (q_count >= 14) ? 30 : 50;
        if ($urandom_range(0, 99) < enq_pct)
        begin
            it.tick = OP_ENQ;
            if ($urandom_range(0, 1) == 0)
                it.dev = DEV_W'($urandom_range(0, 7));
            case ($urandom_range(0, 19))
                0:       it.delay = $urandom;
                1, 2, 3: it.delay = $urandom_range(16, 200);
                default: it.delay = $urandom_range(0, 15);
            endcase
        end
        else
        begin
            it.tick = OP_TICK;
            if ($urandom_range(0, 19) == 0)
                wall_ms = $urandom;
            else
                wall_ms = wall_ms + $urandom_range(0, 6);
            it.now = wall_ms;
        end
        return it;
    endfunction

    task automatic offer_beat(input item_t it);
        logic [IN_TDATA_W-1:0] word;
        word = '0;
        word[IN_DEV_LSB +: DEV_W]    = it.dev;
        word[IN_TAG_LSB +: TAG_W]    = it.tag;
        word[IN_DELAY_LSB +: TIME_W] = it.delay;
        word[IN_NOW_LSB +: TIME_W]   = it.now;
        @(negedge clk);
        while (tx_gaps && $urandom_range(0, 99) < 12)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= it.tick;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        advance_schedule(it);
        beats_sent++;
        if (it.tick == OP_ENQ)
            enq_sent++;
    endtask

    // receiver: random stalls, or a counted hold-off
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_cycles--;
            end
            else if (rx_gaps)
                m_axis_tready <= ($urandom_range(0, 99) >= 12);
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : watch_events
        sched_ev_t got;
        sched_ev_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.ev.kind = m_axis_tuser;
            got.ev.dev  = m_axis_tdata[OUT_DEV_LSB +: DEV_W];
            got.ev.tag  = m_axis_tdata[OUT_TAG_LSB +: TAG_W];
            got.ev.pend = m_axis_tdata[OUT_PEND_LSB +: PEND_W];
            got.last    = m_axis_tlast;
            kind_seen[got.ev.kind]++;
            if (due_events.size() == 0)
                note_fault($sformatf(
                    "unexpected event kind %0d dev %0d tag %0d pend %0d last %0d",
                    got.ev.kind, got.ev.dev, got.ev.tag, got.ev.pend, got.last));
            else
            begin
                want = due_events.pop_front();
                if (got !== want)
                    note_fault({$sformatf(
                        "event mismatch exp kind %0d dev %0d tag %0d pend %0d last %0d,",
                        want.ev.kind, want.ev.dev, want.ev.tag, want.ev.pend, want.last),
                        $sformatf(" got kind %0d dev %0d tag %0d pend %0d last %0d",
                        got.ev.kind, got.ev.dev, got.ev.tag, got.ev.pend, got.last)});
            end
        end
    end

    initial
    begin : stimulus
        plan_row_t r;
        sched_ev_t e;
        item_t     it;
        int        waited;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_ENQ;
        wall_ms       = 32'hFFFF_FF00;
        for (int k = 0; k < NDEV; k++)
            dev_busy[k] = 1'b0;

        // directed table
        plan_row(OP_TICK, 0, 0, 0, 0, 1'b1, EV_ACCEPT, 0);
        plan_row(OP_ENQ, 0, 0, 0, 0, 1'b1, EV_ACCEPT, 1);
        plan_row(OP_ENQ, 127, 255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, EV_ACCEPT, 2);
        plan_row(OP_ENQ, 0, 8'h5A, 5, 0, 1'b1, EV_ACCEPT, 3);
        plan_row(OP_TICK, 0, 0, 0, 32'hFFFF_FFF0, 1'b0, EV_ACCEPT, 0);
        plan_row(OP_TICK, 127, 255, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 1'b0, EV_ACCEPT, 0);
        plan_row(OP_TICK, 0, 0, 0, 32'h0000_0003, 1'b0, EV_ACCEPT, 0);
        for (int k = 0; k < 15; k++)
            plan_row(OP_ENQ, DEV_W'(8 * k + 1), TAG_W'(16 * k + 3), k, 0, 1'b1,
                     EV_ACCEPT, k + 2);
        plan_row(OP_ENQ, 64, 8'h77, 9, 0, 1'b1, EV_DROP, QDEPTH);
        plan_row(OP_TICK, 0, 0, 0, 32'h0000_0010, 1'b0, EV_ACCEPT, 0);
        plan_row(OP_TICK, 0, 0, 0, 32'hFFFF_FFEF, 1'b0, EV_ACCEPT, 0);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[k])
        begin
            r = plan[k];
            offer_beat(r.beat);
            if (!r.typed)
                foreach (step_events[j])
                    due_events = {due_events, step_events[j]};
            else if (r.beat.tick == OP_ENQ)
            begin
                e.ev.kind = r.kind;
                e.ev.dev  = r.beat.dev;
                e.ev.tag  = r.beat.tag;
                e.ev.pend = r.pend;
                e.last    = 1'b1;
                due_events = {due_events, e};
            end
        end

        for (int k = 0; k < N_RANDOM; k++)
        begin
            tx_gaps = !(k >= 120 && k < 170);
            rx_gaps = tx_gaps;
            it = next_request();
            offer_beat(it);
            foreach (step_events[j])
                due_events = {due_events, step_events[j]};
            if (k == 90)
                hold_cycles = 300;
            if (k == 180)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                while (due_events.size() != 0)
                    @(posedge clk);
            end
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b0;

        waited = 0;
        while (due_events.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (100) @(posedge clk);
        if (due_events.size() != 0)
            note_fault($sformatf("%0d events never arrived", due_events.size()));

        $display("Sent %0d beats (%0d enqueues, %0d ticks) %s",
                 beats_sent, enq_sent, beats_sent - enq_sent,
                 "incl. full queue, wrap, 16-event scan.");
        $display("Events: %0d accepted, %0d dropped, %0d sent, %0d completed; %0d faults.",
                 kind_seen[EV_ACCEPT], kind_seen[EV_DROP], kind_seen[EV_SEND],
                 kind_seen[EV_DONE], faults);
        if (faults == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
